// File: src/dll_pkg.sv
// Package for the doubly linked list cursor engine: sizes, request codes and word types.
package dll_pkg;
    localparam int CAPACITY = 64;
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    localparam logic [4:0] REQ_CLEAR      = 5'd0;
    localparam logic [4:0] REQ_INS_FIRST  = 5'd1;
    localparam logic [4:0] REQ_INS_LAST   = 5'd2;
    localparam logic [4:0] REQ_CUR_FIRST  = 5'd3;
    localparam logic [4:0] REQ_CUR_LAST   = 5'd4;
    localparam logic [4:0] REQ_GET_FIRST  = 5'd5;
    localparam logic [4:0] REQ_GET_LAST   = 5'd6;
    localparam logic [4:0] REQ_DEL_FIRST  = 5'd7;
    localparam logic [4:0] REQ_DEL_LAST   = 5'd8;
    localparam logic [4:0] REQ_DEL_AFTER  = 5'd9;
    localparam logic [4:0] REQ_DEL_BEFORE = 5'd10;
    localparam logic [4:0] REQ_INS_AFTER  = 5'd11;
    localparam logic [4:0] REQ_INS_BEFORE = 5'd12;
    localparam logic [4:0] REQ_GET_CUR    = 5'd13;
    localparam logic [4:0] REQ_SET_CUR    = 5'd14;
    localparam logic [4:0] REQ_NEXT       = 5'd15;
    localparam logic [4:0] REQ_PREV       = 5'd16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic               cursor_active;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture request
        logic rd1;    // issue first memory reads
        logic rd2;    // issue second memory reads
        logic exec;   // apply writes and form the result
    } dll_cmd_t;

    typedef struct packed {
        logic need_rd2;
    } dll_sts_t;
endpackage

// File: src/dll_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/dll_ctrl.sv
// Sequencer for the list engine: load, up to two read rounds, execute, respond.
module dll_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dll_pkg::dll_sts_t sts,
    output dll_pkg::dll_cmd_t cmd
);
    import dll_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC} state_t;
    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // A new word may enter while the previous result waits; it holds before its
    // first read round until the output register frees.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.rd1 = 1'b1;
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                if (sts.need_rd2)
                begin
                    cmd.rd2 = 1'b1;
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid) else $error("result not presented");
    a_load_goes_rd1: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_RD1) else $error("load sequence broken");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready) else $error("ready while busy");
`endif
endmodule

// File: src/dll_datapath.sv
// Datapath for the list engine: node memories, list pointers and result register.
module dll_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  dll_pkg::req_t     req,
    input  dll_pkg::dll_cmd_t cmd,
    output dll_pkg::dll_sts_t sts,
    output dll_pkg::rsp_t     rsp
);
    import dll_pkg::*;

    logic [4:0]        req_reg;
    logic [31:0]       val_reg;
    logic [IW-1:0]     head_reg, tail_reg, cur_reg, free_reg;
    logic [IW-1:0]     fresh_reg;
    rsp_t              rsp_reg;

    // Round one: target node links; round two: victim links or free chain head link.
    logic [AW-1:0] ra_v, ra_n, ra_p;
    logic [31:0]   rd_v;
    logic [IW-1:0] rd_n, rd_p;
    logic [IW-1:0] tgt;           // node whose links round one reads
    logic [IW-1:0] t_next, t_prev; // latched round one data
    logic          rd1_d;

    // Up to two link writes per link RAM per request; node memories are split into
    // value, next and prev RAMs, and the second link write follows execute.
    logic          we_v, we_n, we_p;
    logic [AW-1:0] wa_v, wa_n, wa_p;
    logic [31:0]   wd_v;
    logic [IW-1:0] wd_n, wd_p;

    dll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(we_v), .waddr(wa_v), .wdata(wd_v), .raddr(ra_v), .rdata(rd_v));
    dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(we_n), .waddr(wa_n), .wdata(wd_n), .raddr(ra_n), .rdata(rd_n));
    dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
        .clk(clk), .we(we_p), .waddr(wa_p), .wdata(wd_p), .raddr(ra_p), .rdata(rd_p));

    function automatic logic live(input logic [IW-1:0] i);
        return i < NIL;
    endfunction

    always_comb
    begin
        case (req_reg)
            REQ_GET_FIRST, REQ_DEL_FIRST: tgt = head_reg;
            REQ_GET_LAST, REQ_DEL_LAST:   tgt = tail_reg;
            default:                      tgt = cur_reg;
        endcase
    end

    logic is_dnb;
    assign is_dnb = (req_reg == REQ_DEL_AFTER) || (req_reg == REQ_DEL_BEFORE);
    // Delete beside the cursor needs the victim's links in the second round.
    logic [IW-1:0] victim;
    assign victim = (req_reg == REQ_DEL_AFTER) ? rd_n : rd_p;
    assign sts.need_rd2 = 1'b1;

    always_comb
    begin
        ra_v = tgt[AW-1:0];
        ra_n = tgt[AW-1:0];
        ra_p = tgt[AW-1:0];
        if (cmd.rd2)
        begin
            if (is_dnb)
            begin
                ra_n = victim[AW-1:0];
                ra_p = victim[AW-1:0];
            end
            else
            begin
                ra_n = free_reg[AW-1:0];
            end
        end
    end

    // Second-round data: victim links or free chain successor.
    logic [IW-1:0] v_next, v_prev, v_idx, free_succ;
    always_ff @(posedge clk)
    begin
        if (rd1_d)
        begin
            t_next <= rd_n;
            t_prev <= rd_p;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd1_d <= 1'b0;
        end
        else
        begin
            rd1_d <= cmd.rd1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.rd2)
        begin
            v_idx <= victim;
        end
    end
    assign v_next = rd_n;
    assign v_prev = rd_p;
    assign free_succ = rd_n;

    // Execute decides up to two writes to each link RAM. The second one is
    // carried out from a small write queue on the following cycle.
    typedef struct packed {
        logic          en;
        logic [AW-1:0] a;
        logic [IW-1:0] d;
    } lw_t;
    lw_t qn_reg [2], qp_reg [2];
    lw_t qn_next [2], qp_next [2];
    logic [1:0] qcnt_reg;

    logic [IW-1:0] head_n, tail_n, cur_n, free_n, fresh_n;
    rsp_t          rsp_n;
    logic          wv_en;
    logic [AW-1:0] wv_a;
    logic [31:0]   value_cur;

    assign value_cur = rd_v;

    always_comb
    begin
        logic [IW-1:0] n, q, p, c, x;
        logic [IW-1:0] a_free, a_fresh;
        logic          got;
        head_n = head_reg; tail_n = tail_reg; cur_n = cur_reg;
        free_n = free_reg; fresh_n = fresh_reg;
        rsp_n = '0;
        wv_en = 1'b0; wv_a = '0;
        for (int k = 0; k < 2; k++)
        begin
            qn_next[k] = '0;
            qp_next[k] = '0;
        end
        c = cur_reg;
        n = NIL; got = 1'b0; x = NIL; q = NIL; p = NIL;
        a_free = free_reg; a_fresh = fresh_reg;
        if (live(free_reg))
        begin
            n = free_reg; got = 1'b1; a_free = free_succ;
        end
        else if (fresh_reg < NIL)
        begin
            n = fresh_reg; got = 1'b1; a_fresh = fresh_reg + 1'b1;
        end
        case (req_reg)
            REQ_CLEAR:
            begin
                head_n = NIL; tail_n = NIL; cur_n = NIL; free_n = NIL; fresh_n = '0;
            end
            REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AFTER, REQ_INS_BEFORE:
            begin
                // Inserting beside an inactive cursor changes nothing.
                if (!((req_reg == REQ_INS_AFTER || req_reg == REQ_INS_BEFORE) && !live(c)))
                begin
                    if (!got)
                    begin
                        rsp_n.status = ST_FULL;
                    end
                    else
                    begin
                        free_n = a_free; fresh_n = a_fresh;
                        wv_en = 1'b1; wv_a = n[AW-1:0];
                        if (req_reg == REQ_INS_FIRST)
                        begin
                            q = head_reg; p = NIL;
                        end
                        else if (req_reg == REQ_INS_LAST)
                        begin
                            q = NIL; p = tail_reg;
                        end
                        else if (req_reg == REQ_INS_AFTER)
                        begin
                            q = t_next; p = c;
                        end
                        else
                        begin
                            q = c; p = t_prev;
                        end
                        qn_next[0] = '{1'b1, n[AW-1:0], q};
                        qp_next[0] = '{1'b1, n[AW-1:0], p};
                        if (live(q)) qp_next[1] = '{1'b1, q[AW-1:0], n};
                        else tail_n = n;
                        if (live(p)) qn_next[1] = '{1'b1, p[AW-1:0], n};
                        else head_n = n;
                    end
                end
            end
            REQ_CUR_FIRST: cur_n = head_reg;
            REQ_CUR_LAST:  cur_n = tail_reg;
            REQ_GET_FIRST, REQ_GET_LAST, REQ_GET_CUR:
            begin
                if (live(tgt)) rsp_n.read_value = value_cur;
                else rsp_n.status = ST_EMPTY;
            end
            REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AFTER, REQ_DEL_BEFORE:
            begin
                if (is_dnb)
                begin
                    x = live(c) ? v_idx : NIL; q = v_next; p = v_prev;
                end
                else
                begin
                    x = tgt; q = t_next; p = t_prev;
                end
                if (live(x))
                begin
                    if (live(p)) qn_next[0] = '{1'b1, p[AW-1:0], q};
                    else head_n = q;
                    if (live(q)) qp_next[0] = '{1'b1, q[AW-1:0], p};
                    else tail_n = p;
                    if (cur_reg == x) cur_n = NIL;
                    qn_next[1] = '{1'b1, x[AW-1:0], free_reg};
                    qp_next[1] = '{1'b1, x[AW-1:0], NIL};
                    free_n = x;
                end
            end
            REQ_SET_CUR:
            begin
                if (live(c))
                begin
                    wv_en = 1'b1; wv_a = c[AW-1:0];
                end
            end
            REQ_NEXT: if (live(c)) cur_n = t_next;
            REQ_PREV: if (live(c)) cur_n = t_prev;
            default: ;
        endcase
        rsp_n.cursor_active = live(cur_n);
    end

    // Writes: value RAM in execute; link RAMs drain the queue, entry 0 in
    // execute and entry 1 on the next cycle (the controller idles then).
    assign we_v = cmd.exec && wv_en;
    assign wa_v = wv_a;
    assign wd_v = val_reg;
    always_comb
    begin
        if (cmd.exec)
        begin
            we_n = qn_next[0].en; wa_n = qn_next[0].a; wd_n = qn_next[0].d;
            we_p = qp_next[0].en; wa_p = qp_next[0].a; wd_p = qp_next[0].d;
        end
        else
        begin
            we_n = qn_reg[1].en && qcnt_reg != 2'd0;
            wa_n = qn_reg[1].a; wd_n = qn_reg[1].d;
            we_p = qp_reg[1].en && qcnt_reg != 2'd0;
            wa_p = qp_reg[1].a; wd_p = qp_reg[1].d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req.req_type;
            val_reg <= req.value_in;
        end
        if (cmd.exec)
        begin
            qn_reg <= qn_next;
            qp_reg <= qp_next;
            rsp_reg <= rsp_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL; tail_reg <= NIL; cur_reg <= NIL;
            free_reg <= NIL; fresh_reg <= '0; qcnt_reg <= '0;
        end
        else
        begin
            qcnt_reg <= cmd.exec ? 2'd1 : 2'd0;
            if (cmd.exec)
            begin
                head_reg <= head_n; tail_reg <= tail_n; cur_reg <= cur_n;
                free_reg <= free_n; fresh_reg <= fresh_n;
            end
        end
    end

    assign rsp = rsp_reg;

`ifndef NO_ASSERTIONS
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL) else $error("fresh count overflow");
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        live(head_reg) == live(tail_reg)) else $error("head and tail disagree");
    a_cur_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !live(head_reg) |-> !live(cur_reg)) else $error("cursor on empty list");
`endif
endmodule

// File: src/doubly_linked_list_cursor_engine.sv
// Top level of the doubly linked list cursor engine.
// A request word is accepted while the engine is idle and its result is presented
// after two rounds of registered reads from the node memories (the second reads the
// free chain successor or the links of a node beside the cursor) and an execute
// step that updates the pointers and writes the node RAMs. A second link write
// lands in the cycle after execute, when the engine is idle again; a new word is
// taken only once the previous one has executed. A new word is accepted while the
// previous result waits in the output register; it holds before its first read
// round until that result is taken. Clear empties the list in one request.
// There is no clearing pass after reset.
module doubly_linked_list_cursor_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dll_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dll_pkg::rsp_t out_data
);
    import dll_pkg::*;

    dll_cmd_t cmd;
    dll_sts_t sts;

    dll_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    dll_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data));
endmodule
